FILE: src/dtt_pkg.sv
// ----------------------------------------------------------------------------
// Dual touch tap detector package
// Shared widths, codes, reset values and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int READING_W  = 16;
  localparam int TIME_W     = 32;
  localparam int EVENT_W    = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int HISTORY_DEPTH_DEFAULT = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SENSE_LEVEL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW  = 8'd1;

  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 16'd40;
  localparam logic [CFG_DATA_W-1:0] WINDOW_RESET    = 16'd400;

  // Tap machine states.
  localparam logic [1:0] TAP_WAIT     = 2'd0;
  localparam logic [1:0] TAP_TOUCHED  = 2'd1;
  localparam logic [1:0] TAP_RELEASED = 2'd2;
  localparam logic [1:0] TAP_AGAIN    = 2'd3;

  // Result codes.
  localparam logic [EVENT_W-1:0] EV_NONE       = 3'd0;
  localparam logic [EVENT_W-1:0] EV_ONE_SINGLE = 3'd1;
  localparam logic [EVENT_W-1:0] EV_ONE_DOUBLE = 3'd2;
  localparam logic [EVENT_W-1:0] EV_TWO_SINGLE = 3'd3;
  localparam logic [EVENT_W-1:0] EV_TWO_DOUBLE = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take a request: write history, latch time, start scan
    logic scan_step;  // examine one history entry
    logic decide;     // run the tap machines and load the result register
  } dtt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // current entry is marked or is the last entry
  } dtt_status_t;

endpackage

FILE: src/dtt_if.sv
// ----------------------------------------------------------------------------
// Dual touch tap detector channels
// Valid/ready channels for samples, tap results and configuration writes.
// ----------------------------------------------------------------------------
interface dtt_sample_if;
  logic                           valid;
  logic                           ready;
  logic [dtt_pkg::READING_W-1:0]  reading_one;
  logic [dtt_pkg::READING_W-1:0]  reading_two;
  logic [dtt_pkg::TIME_W-1:0]     now_ms;

  modport source (output valid, output reading_one, output reading_two,
                  output now_ms, input ready);
  modport sink   (input valid, input reading_one, input reading_two,
                  input now_ms, output ready);
endinterface

interface dtt_event_if;
  logic                         valid;
  logic                         ready;
  logic [dtt_pkg::EVENT_W-1:0]  tap_event;

  modport source (output valid, output tap_event, input ready);
  modport sink   (input valid, input tap_event, output ready);
endinterface

interface dtt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dtt_pkg::CFG_IDX_W-1:0]   index;
  logic [dtt_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/dtt_ctrl.sv
// ----------------------------------------------------------------------------
// Dual touch tap detector controller
// Sequences capture, history scan and decision; owns the result valid flag.
// ----------------------------------------------------------------------------
module dtt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dtt_pkg::dtt_status_t status,
  output dtt_pkg::dtt_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    cmd.capture   = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.decide    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // The result register must be free before it is overwritten.
        if (out_free) begin
          cmd.decide = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.decide) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/dtt_datapath.sv
// ----------------------------------------------------------------------------
// Dual touch tap detector datapath
// History ring, presence scan, two tap machines, config and result registers.
// ----------------------------------------------------------------------------
module dtt_datapath #(
  parameter int HISTORY_DEPTH = dtt_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dtt_pkg::dtt_cmd_t                cmd,
  output dtt_pkg::dtt_status_t             status,
  input  logic [dtt_pkg::READING_W-1:0]    reading_one,
  input  logic [dtt_pkg::READING_W-1:0]    reading_two,
  input  logic [dtt_pkg::TIME_W-1:0]       now_ms,
  input  logic                             cfg_we,
  input  logic [dtt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dtt_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [dtt_pkg::EVENT_W-1:0]      tap_event
);

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

  logic [dtt_pkg::CFG_DATA_W-1:0] sense_level;
  logic [dtt_pkg::CFG_DATA_W-1:0] double_tap_window_ms;

  logic [1:0]              touch_history [HISTORY_DEPTH];
  logic [IDX_W-1:0]        write_slot;
  logic [IDX_W-1:0]        scan_idx;
  logic                    pres_one;
  logic                    pres_two;
  logic [dtt_pkg::TIME_W-1:0] sample_time;

  logic [1:0]              tap_state_one;
  logic [1:0]              tap_state_two;
  logic                    seen_one;
  logic                    seen_two;
  logic [dtt_pkg::TIME_W-1:0] release_time;

  logic [1:0]              entry;
  logic [1:0]              mark;

  // Decision logic.
  logic                    act_one;
  logic                    act_two;
  logic                    present;
  logic [1:0]              cur_state;
  logic [1:0]              new_state;
  logic [1:0]              tap_code;   // 0 none, 1 single, 2 double
  logic                    store_release;
  logic [dtt_pkg::TIME_W-1:0] elapsed;
  logic                    expired;
  logic [dtt_pkg::EVENT_W-1:0] event_code;

  assign entry = touch_history[scan_idx];
  assign status.scan_done = (entry != 2'b00) || (scan_idx == LAST_IDX);

  assign mark[0] = (reading_one < sense_level);
  assign mark[1] = (reading_two < sense_level);

  assign act_one = (seen_one != pres_one) || (tap_state_one == dtt_pkg::TAP_RELEASED);
  assign act_two = !act_one &&
                   ((seen_two != pres_two) || (tap_state_two == dtt_pkg::TAP_RELEASED));

  // Only one machine acts per sample, so both share one timer compare.
  assign present   = act_one ? pres_one : pres_two;
  assign cur_state = act_one ? tap_state_one : tap_state_two;
  assign elapsed   = sample_time - release_time;
  assign expired   = elapsed > {{(dtt_pkg::TIME_W - dtt_pkg::CFG_DATA_W){1'b0}},
                                double_tap_window_ms};

  always_comb begin
    new_state     = cur_state;
    tap_code      = 2'd0;
    store_release = 1'b0;
    case (cur_state)
      dtt_pkg::TAP_WAIT: begin
        if (present) new_state = dtt_pkg::TAP_TOUCHED;
      end
      dtt_pkg::TAP_TOUCHED: begin
        if (!present) begin
          new_state     = dtt_pkg::TAP_RELEASED;
          store_release = 1'b1;
        end
      end
      dtt_pkg::TAP_RELEASED: begin
        if (present) begin
          new_state = dtt_pkg::TAP_AGAIN;
        end else if (expired) begin
          new_state = dtt_pkg::TAP_WAIT;
          tap_code  = 2'd1;
        end
      end
      default: begin
        if (!present) begin
          new_state = dtt_pkg::TAP_WAIT;
          tap_code  = 2'd2;
        end
      end
    endcase
  end

  always_comb begin
    event_code = dtt_pkg::EV_NONE;
    if (act_one) begin
      case (tap_code)
        2'd1:    event_code = dtt_pkg::EV_ONE_SINGLE;
        2'd2:    event_code = dtt_pkg::EV_ONE_DOUBLE;
        default: event_code = dtt_pkg::EV_NONE;
      endcase
    end else if (act_two) begin
      case (tap_code)
        2'd1:    event_code = dtt_pkg::EV_TWO_SINGLE;
        2'd2:    event_code = dtt_pkg::EV_TWO_DOUBLE;
        default: event_code = dtt_pkg::EV_NONE;
      endcase
    end
  end

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      sense_level          <= dtt_pkg::THRESHOLD_RESET;
      double_tap_window_ms <= dtt_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      if (cfg_index == dtt_pkg::CFG_SENSE_LEVEL) sense_level <= cfg_data;
      if (cfg_index == dtt_pkg::CFG_TAP_WINDOW) double_tap_window_ms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) touch_history[i] <= 2'b00;
      write_slot    <= '0;
      scan_idx      <= '0;
      pres_one      <= 1'b0;
      pres_two      <= 1'b0;
      tap_state_one <= dtt_pkg::TAP_WAIT;
      tap_state_two <= dtt_pkg::TAP_WAIT;
      seen_one      <= 1'b0;
      seen_two      <= 1'b0;
      release_time  <= '0;
    end else begin
      if (cmd.capture) begin
        touch_history[write_slot] <= mark;
        write_slot <= (write_slot == LAST_IDX) ? '0 : write_slot + 1'b1;
        scan_idx   <= '0;
        pres_one   <= 1'b0;
        pres_two   <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (entry[0]) begin
          pres_one <= 1'b1;
        end else if (entry[1]) begin
          pres_two <= 1'b1;
        end else if (scan_idx != LAST_IDX) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (cmd.decide) begin
        if (act_one) begin
          seen_one      <= pres_one;
          tap_state_one <= new_state;
        end else if (act_two) begin
          seen_two      <= pres_two;
          tap_state_two <= new_state;
        end
        if ((act_one || act_two) && store_release) begin
          release_time <= sample_time;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) sample_time <= now_ms;
    if (cmd.decide)  tap_event   <= event_code;
  end

endmodule

FILE: src/dual_touch_tap_detector.sv
// ----------------------------------------------------------------------------
// Dual touch tap detector
// Two-sensor capacitive touch front end reporting single and double taps.
// ----------------------------------------------------------------------------
// Flow: a request passes through capture, a scan of k ring entries, where k
// (1 to HISTORY_DEPTH) is the count scanned up to the first marked entry or
// the last one, and decide; a result still waiting on the output stalls decide.
// A new request is taken only once the last one is decided. Reset: synchronous,
// active high; clears history, tap machines and timers and restores the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
module dual_touch_tap_detector #(
  parameter int HISTORY_DEPTH = dtt_pkg::HISTORY_DEPTH_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  dtt_sample_if.sink   samples,
  dtt_event_if.source  taps,
  dtt_cfg_if.sink      cfg
);

  // The controller walks each request through three phases: capture, where
  // the touch marks are written into the history ring and the timestamp is
  // latched; scan, one ring entry per cycle from entry zero upward until an
  // entry holds a mark or is the last; and decide, where at most one tap
  // machine steps and the result register is loaded. The result register
  // decouples the output side; new requests are taken while a result drains.
  dtt_pkg::dtt_cmd_t    cmd;
  dtt_pkg::dtt_status_t status;
  logic                 cfg_we;

  // Configuration writes are always taken; the user must issue them only when idle, as the block does not enforce it.
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  dtt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (taps.valid),
    .out_ready (taps.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the ring, the shared release time and both machines.
  dtt_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .reading_one (samples.reading_one),
    .reading_two (samples.reading_two),
    .now_ms      (samples.now_ms),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .tap_event   (taps.tap_event)
  );

endmodule
